### rtl/qoi_pkg.sv
package qoi_pkg;

    localparam int CHAN_W         = 8;
    localparam int PIX_W          = 3 * CHAN_W;
    localparam int RUN_W          = 6;
    localparam int INDEX_SLOTS    = 64;
    localparam int SLOT_W         = $clog2(INDEX_SLOTS);
    localparam int MAX_CODE_BYTES = 5;
    localparam int CNT_W          = $clog2(MAX_CODE_BYTES + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int DEF_MAX_RUN    = 62;

    localparam logic [CHAN_W-1:0] OP_INDEX = 8'h00;
    localparam logic [CHAN_W-1:0] OP_DIFF  = 8'h40;
    localparam logic [CHAN_W-1:0] OP_LUMA  = 8'h80;
    localparam logic [CHAN_W-1:0] OP_RUN   = 8'hC0;
    localparam logic [CHAN_W-1:0] OP_RGB   = 8'hFE;

    // All bytes caused by one pixel, lowest element sent first.
    typedef struct packed {
        logic [CNT_W-1:0]                         count;
        logic [MAX_CODE_BYTES-1:0][CHAN_W-1:0]    bytes;
    } qoi_code_t;

endpackage

### rtl/qoi_front.sv
module qoi_front
    import qoi_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PIX_W-1:0]        s_tdata,
    input  logic                    s_tlast,
    output logic                    push,
    output qoi_code_t               code,
    input  logic                    full
);

    logic [PIX_W-1:0]  pix_in;
    logic [SLOT_W-1:0] slot_in;
    logic              accept;
    logic              advance;
    logic              wr;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [PIX_W-1:0]  s1_prev_reg;
    logic              s1_last_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_fwd_reg;
    logic [PIX_W-1:0]  prev_reg;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;

    logic [PIX_W-1:0]       index_mem [INDEX_SLOTS];
    logic [INDEX_SLOTS-1:0] index_valid_reg;
    logic [PIX_W-1:0]       rd_data_reg;
    logic                   rd_valid_reg;

    logic signed [CHAN_W-1:0] dr;
    logic signed [CHAN_W-1:0] dg;
    logic signed [CHAN_W-1:0] db;
    logic signed [CHAN_W:0]   drg;
    logic signed [CHAN_W:0]   dbg;
    logic                     eq;
    logic                     diff_ok;
    logic                     luma_ok;
    logic [PIX_W-1:0]         entry;
    logic                     hit;
    logic [RUN_W-1:0]         rc1;
    logic                     flush;
    logic [RUN_W-1:0]         flush_len;
    logic [CHAN_W-1:0]        run_byte;
    logic [3:0][CHAN_W-1:0]   op_bytes;
    logic [CNT_W-1:0]         op_cnt;

    // Pixel held as {red, green, blue}; the stream carries red in the low byte.
    assign pix_in  = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign slot_in = SLOT_W'(3 * pix_in[23:16] + 5 * pix_in[15:8] + 7 * pix_in[7:0]);
    assign accept  = s_tvalid && s_tready;

    always_comb
    begin
        dr  = s1_pix_reg[23:16] - s1_prev_reg[23:16];
        dg  = s1_pix_reg[15:8]  - s1_prev_reg[15:8];
        db  = s1_pix_reg[7:0]   - s1_prev_reg[7:0];
        drg = {dr[CHAN_W-1], dr} - {dg[CHAN_W-1], dg};
        dbg = {db[CHAN_W-1], db} - {dg[CHAN_W-1], dg};
        eq  = (s1_pix_reg == s1_prev_reg);

        diff_ok = (dr >= -8'sd2) && (dr <= 8'sd1) && (dg >= -8'sd2) && (dg <= 8'sd1)
               && (db >= -8'sd2) && (db <= 8'sd1);
        luma_ok = (dg >= -8'sd32) && (dg <= 8'sd31) && (drg >= -9'sd8) && (drg <= 9'sd7)
               && (dbg >= -9'sd8) && (dbg <= 9'sd7);

        // The item just ahead wrote this slot at the edge our read was taken.
        if (s1_fwd_reg)
        begin
            entry = s1_prev_reg;
        end
        else if (rd_valid_reg)
        begin
            entry = rd_data_reg;
        end
        else
        begin
            entry = '0;
        end
        hit = (entry == s1_pix_reg);

        op_bytes = '0;
        if (eq)
        begin
            op_cnt = '0;
        end
        else if (diff_ok)
        begin
            op_cnt      = CNT_W'(1);
            op_bytes[0] = OP_DIFF | {2'b00, 2'(dr + 8'sd2), 2'(dg + 8'sd2), 2'(db + 8'sd2)};
        end
        else if (luma_ok)
        begin
            op_cnt      = CNT_W'(2);
            op_bytes[0] = OP_LUMA | {2'b00, 6'(dg + 8'sd32)};
            op_bytes[1] = {4'(drg + 9'sd8), 4'(dbg + 9'sd8)};
        end
        else if (hit)
        begin
            op_cnt      = CNT_W'(1);
            op_bytes[0] = OP_INDEX | {2'b00, s1_slot_reg};
        end
        else
        begin
            op_cnt      = CNT_W'(4);
            op_bytes[0] = OP_RGB;
            op_bytes[1] = s1_pix_reg[23:16];
            op_bytes[2] = s1_pix_reg[15:8];
            op_bytes[3] = s1_pix_reg[7:0];
        end

        rc1 = run_reg + RUN_W'(1);
        if (eq)
        begin
            flush_len = rc1;
            if (rc1 >= RUN_W'(MAX_RUN) || s1_last_reg)
            begin
                flush    = 1'b1;
                run_next = '0;
            end
            else
            begin
                flush    = 1'b0;
                run_next = rc1;
            end
        end
        else
        begin
            flush_len = run_reg;
            flush     = (run_reg != '0);
            run_next  = '0;
        end
        run_byte = OP_RUN | {2'b00, flush_len - RUN_W'(1)};

        if (flush)
        begin
            code.bytes = {op_bytes, run_byte};
            code.count = op_cnt + CNT_W'(1);
        end
        else
        begin
            code.bytes = {{CHAN_W{1'b0}}, op_bytes};
            code.count = op_cnt;
        end

        advance  = s1_valid_reg && ((code.count == '0) || !full);
        s_tready = !s1_valid_reg || advance;
        push     = advance && (code.count != '0);
        wr       = advance && !eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            prev_reg        <= '0;
            run_reg         <= '0;
            index_valid_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                prev_reg     <= pix_in;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                run_reg <= run_next;
            end
            if (wr)
            begin
                index_valid_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pix_in;
            s1_prev_reg  <= prev_reg;
            s1_last_reg  <= s_tlast;
            s1_slot_reg  <= slot_in;
            s1_fwd_reg   <= wr && (s1_slot_reg == slot_in);
            rd_data_reg  <= index_mem[slot_in];
            rd_valid_reg <= index_valid_reg[slot_in];
        end
        if (wr)
        begin
            index_mem[s1_slot_reg] <= s1_pix_reg;
        end
    end

endmodule

### rtl/qoi_fifo.sv
module qoi_fifo
    import qoi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  qoi_code_t push_data,
    output logic      full,
    input  logic      pop,
    output qoi_code_t pop_data,
    output logic      not_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    qoi_code_t          entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;

    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/qoi_back.sv
module qoi_back
    import qoi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  qoi_code_t         q_data,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAN_W-1:0] m_tdata,
    output logic              m_tlast
);

    qoi_code_t        cur_reg;
    logic             cur_valid_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             last_byte;
    logic             done;

    assign last_byte = (idx_reg == cur_reg.count - CNT_W'(1));
    assign done      = m_tready && last_byte;
    assign pop       = q_valid && (!cur_valid_reg || done);
    assign m_tvalid  = cur_valid_reg;
    assign m_tdata   = cur_reg.bytes[idx_reg];
    assign m_tlast   = last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (cur_valid_reg && done)
            begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (cur_valid_reg && m_tready)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
        end
    end

endmodule

### rtl/qoi_rgb_pixel_encoder.sv
// Channel   Direction  Transaction carries
// s_*       in         one RGB pixel; tlast marks the final pixel of the image
// m_*       out        one byte of the compressed stream; tlast marks the last
//                      byte caused by a given pixel
//
// A pixel is accepted in any cycle in which the classifier stage is free or is
// handing its codes to the queue, so pixels enter one per cycle while the four
// entry queue has room. Each pixel is classified in the cycle after acceptance.
// Bytes leave at one per cycle while m_tready is high; a pixel yields zero to
// five bytes, so the sustained pixel rate is set by the output byte port.
// Reset clears the previous pixel to black, the run count and the colour index
// valid bits, so the index reads as all black; no clearing pass is needed.
// Either side may stall at any time; the queue decouples them.
module qoi_rgb_pixel_encoder
    import qoi_pkg::*;
#(
    parameter int MAX_RUN = DEF_MAX_RUN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // pix_red, pix_green, pix_blue
    input  logic              s_tlast,   // last_pixel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAN_W-1:0] m_tdata,   // code_byte
    output logic              m_tlast    // pixel_end
);

    // Classifier output: the complete set of code bytes for one pixel.
    qoi_code_t front_code;
    qoi_code_t queue_code;
    logic      front_push;
    logic      queue_full;
    logic      queue_valid;
    logic      queue_pop;

    // The front stage keeps the previous pixel, the pending run and the colour
    // index, and turns each pixel into a run byte, when a run ends, then any op bytes.
    qoi_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (front_push),
        .code     (front_code),
        .full     (queue_full)
    );

    qoi_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_code),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_code),
        .not_empty (queue_valid)
    );

    // The back stage serialises each queued entry, one byte per transaction.
    qoi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (queue_valid),
        .q_data   (queue_code),
        .pop      (queue_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
